[hdl/hfd_pkg.sv]
package hfd_pkg;

    // Flag bits of the frame header that shape the body layout
    localparam logic [7:0] FLAG_PADDED   = 8'b0000_1000;
    localparam logic [7:0] FLAG_PRIORITY = 8'b0010_0000;

    // Frame type codes with a fixed body layout
    localparam logic [7:0] FT_DATA         = 8'd0;
    localparam logic [7:0] FT_HEADERS      = 8'd1;
    localparam logic [7:0] FT_PRIORITY     = 8'd2;
    localparam logic [7:0] FT_RST_STREAM   = 8'd3;
    localparam logic [7:0] FT_SETTINGS     = 8'd4;
    localparam logic [7:0] FT_PUSH_PROMISE = 8'd5;
    localparam logic [7:0] FT_PING         = 8'd6;
    localparam logic [7:0] FT_GOAWAY       = 8'd7;
    localparam logic [7:0] FT_WINDOW       = 8'd8;

    // Field kind codes given out with every byte
    localparam logic [3:0] KIND_HEADER     = 4'd0;
    localparam logic [3:0] KIND_PADLEN     = 4'd1;
    localparam logic [3:0] KIND_DEPENDENCY = 4'd2;
    localparam logic [3:0] KIND_WEIGHT     = 4'd3;
    localparam logic [3:0] KIND_PROMISED   = 4'd4;
    localparam logic [3:0] KIND_ERROR      = 4'd5;
    localparam logic [3:0] KIND_SET_ID     = 4'd6;
    localparam logic [3:0] KIND_SET_VALUE  = 4'd7;
    localparam logic [3:0] KIND_PING       = 4'd8;
    localparam logic [3:0] KIND_LAST_ID    = 4'd9;
    localparam logic [3:0] KIND_WINDOW     = 4'd10;
    localparam logic [3:0] KIND_PAYLOAD    = 4'd11;
    localparam logic [3:0] KIND_PADDING    = 4'd12;

    // Last byte index of the frame header
    localparam logic [3:0] HDR_LAST_BYTE = 4'd8;

    // Parse phase, one-hot
    typedef enum logic [11:0] {
        PH_HDR      = 12'b0000_0000_0001,
        PH_PADLEN   = 12'b0000_0000_0010,
        PH_DEP      = 12'b0000_0000_0100,
        PH_WEIGHT   = 12'b0000_0000_1000,
        PH_PROMISED = 12'b0000_0001_0000,
        PH_ERROR    = 12'b0000_0010_0000,
        PH_SETID    = 12'b0000_0100_0000,
        PH_SETVAL   = 12'b0000_1000_0000,
        PH_PING     = 12'b0001_0000_0000,
        PH_LASTID   = 12'b0010_0000_0000,
        PH_WINDOW   = 12'b0100_0000_0000,
        PH_PAYLOAD  = 12'b1000_0000_0000
    } phase_t;

    // One result item
    typedef struct packed {
        logic        truncated;
        logic        frame_done;
        logic        field_done;
        logic [31:0] field_value;
        logic [23:0] frame_length;
        logic [31:0] stream_id;
        logic [7:0]  frame_flags;
        logic [7:0]  frame_type;
        logic [3:0]  field_kind;
    } result_t;

    // Phase that follows the pad length byte, or opens an unpadded body
    function automatic phase_t phase_after_pad(input logic [7:0] ftype, input logic [7:0] flags);
        phase_t ph;
        begin
            unique case (ftype)
                FT_HEADERS:      ph = ((flags & FLAG_PRIORITY) != 8'd0) ? PH_DEP : PH_PAYLOAD;
                FT_PRIORITY:     ph = PH_DEP;
                FT_RST_STREAM:   ph = PH_ERROR;
                FT_SETTINGS:     ph = PH_SETID;
                FT_PUSH_PROMISE: ph = PH_PROMISED;
                FT_PING:         ph = PH_PING;
                FT_GOAWAY:       ph = PH_LASTID;
                FT_WINDOW:       ph = PH_WINDOW;
                default:         ph = PH_PAYLOAD;
            endcase
            return ph;
        end
    endfunction

    // Phase of the first body byte after the header
    function automatic phase_t first_body_phase(input logic [7:0] ftype, input logic [7:0] flags);
        logic padded_type;
        begin
            padded_type = (ftype == FT_DATA) || (ftype == FT_HEADERS)
                       || (ftype == FT_PUSH_PROMISE);
            if (padded_type && ((flags & FLAG_PADDED) != 8'd0))
                return PH_PADLEN;
            return phase_after_pad(ftype, flags);
        end
    endfunction

    // Phase after a fixed field has been completed
    function automatic phase_t next_phase(input phase_t ph, input logic [7:0] ftype,
                                          input logic [7:0] flags);
        phase_t nxt;
        begin
            unique case (ph)
                PH_PADLEN: nxt = phase_after_pad(ftype, flags);
                PH_DEP:    nxt = PH_WEIGHT;
                PH_SETID:  nxt = PH_SETVAL;
                PH_SETVAL: nxt = PH_SETID;
                PH_LASTID: nxt = PH_ERROR;
                default:   nxt = PH_PAYLOAD;
            endcase
            return nxt;
        end
    endfunction

    // Byte length of a fixed field
    function automatic logic [2:0] field_len(input phase_t ph);
        logic [2:0] len;
        begin
            unique case (ph)
                PH_PADLEN, PH_WEIGHT: len = 3'd1;
                PH_SETID:             len = 3'd2;
                PH_DEP, PH_PROMISED, PH_ERROR, PH_SETVAL,
                PH_PING, PH_LASTID, PH_WINDOW: len = 3'd4;
                default:              len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // Field kind tagged on a byte of a fixed field
    function automatic logic [3:0] phase_kind(input phase_t ph);
        logic [3:0] kind;
        begin
            unique case (ph)
                PH_PADLEN:   kind = KIND_PADLEN;
                PH_DEP:      kind = KIND_DEPENDENCY;
                PH_WEIGHT:   kind = KIND_WEIGHT;
                PH_PROMISED: kind = KIND_PROMISED;
                PH_ERROR:    kind = KIND_ERROR;
                PH_SETID:    kind = KIND_SET_ID;
                PH_SETVAL:   kind = KIND_SET_VALUE;
                PH_PING:     kind = KIND_PING;
                PH_LASTID:   kind = KIND_LAST_ID;
                PH_WINDOW:   kind = KIND_WINDOW;
                PH_PAYLOAD:  kind = KIND_PAYLOAD;
                default:     kind = KIND_HEADER;
            endcase
            return kind;
        end
    endfunction

endpackage

[hdl/http2_frame_deframer_top.sv]
// Channel   Direction  tdata                     tuser                  tlast
// s_axis    in         data_byte                 first_byte             last_byte
// m_axis    out        type,flags,stream,length, field_kind,field_done, frame_done
//                      field_value               truncated
//
// One byte is accepted per clock cycle while s_axis_tready is high; its result is
// registered in the output stage; the parser state update is one registered pass.
// A two-entry output stage (result register plus skid register) takes one more
// transaction when m_axis stalls; s_axis_tready falls only when both entries are
// full and rises again at the edge where the skid entry moves to the output.
// Reset puts the parser at the start of a frame header with all frame
// registers cleared and both output entries empty.
module http2_frame_deframer_top
    import hfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] first_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // frame_type, frame_flags, stream_id,
                                         // frame_length, field_value
    output logic [5:0]   m_axis_tuser,   // field_kind, field_done, truncated
    output logic         m_axis_tlast    // frame_done
);

    logic    accept;
    result_t parse_result;
    result_t out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Byte parser and frame state
    hfd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .first_byte (s_axis_tuser[0]),
        .last_byte  (s_axis_tlast),
        .result     (parse_result)
    );

    // Output register with skid entry
    hfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (parse_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // Pack the result onto the master-side transaction
    assign m_axis_tdata = {out_result.field_value, out_result.frame_length,
                           out_result.stream_id, out_result.frame_flags,
                           out_result.frame_type};
    assign m_axis_tuser = {out_result.truncated, out_result.field_done,
                           out_result.field_kind};
    assign m_axis_tlast = out_result.frame_done;

endmodule

[hdl/hfd_parse.sv]
module hfd_parse
    import hfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output result_t     result
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  bif_reg,    bif_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [23:0] rem_reg,    rem_next;
    logic [7:0]  pad_reg,    pad_next;
    logic [31:0] vshift_reg, vshift_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  flags_reg,  flags_next;
    logic [31:0] stream_reg, stream_next;
    logic [23:0] length_reg, length_next;

    phase_t      ph;
    logic [3:0]  hc;
    logic [3:0]  n;
    logic [2:0]  idx;
    logic [2:0]  idx_inc;
    logic [31:0] vs_shift;
    logic [23:0] rem_dec;
    logic        phase_end;
    logic [3:0]  kind;
    logic [31:0] fval;
    logic        fdone;
    logic        frdone;
    logic        trunc;

    // Next state and result for the byte on the input
    always_comb
    begin
        phase_next   = phase_reg;
        bif_next     = bif_reg;
        rem_next     = rem_reg;
        pad_next     = pad_reg;
        vshift_next  = vshift_reg;
        type_next    = type_reg;
        flags_next   = flags_reg;
        stream_next  = stream_reg;
        length_next  = length_reg;
        kind         = KIND_HEADER;
        fval         = 32'd0;
        fdone        = 1'b0;
        frdone       = 1'b0;
        phase_end    = 1'b0;
        idx          = bif_reg;
        idx_inc      = 3'(bif_reg + 3'd1);
        vs_shift     = {vshift_reg[23:0], data_byte};
        rem_dec      = 24'(rem_reg - 24'd1);
        n            = 4'd0;

        // A packet start restarts at a frame header
        ph = first_byte ? PH_HDR : phase_reg;
        hc = first_byte ? 4'd0 : hdr_cnt_reg;
        hdr_cnt_next = hc;

        if (ph == PH_HDR || rem_reg == 24'd0)
        begin
            // Frame header bytes
            n = (hc > HDR_LAST_BYTE) ? 4'd0 : hc;
            phase_next = PH_HDR;
            case (n) inside
                4'd0:       length_next = {16'd0, data_byte};
                4'd1, 4'd2: length_next = {length_reg[15:0], data_byte};
                4'd3:       type_next   = data_byte;
                4'd4:       flags_next  = data_byte;
                4'd5:       stream_next = {24'd0, data_byte};
                default:    stream_next = {stream_reg[23:0], data_byte};
            endcase
            if (n == HDR_LAST_BYTE)
            begin
                hdr_cnt_next = 4'd0;
                fdone        = 1'b1;
                fval         = {8'd0, length_next};
                rem_next     = length_next;
                pad_next     = 8'd0;
                bif_next     = 3'd0;
                vshift_next  = 32'd0;
                frdone       = (length_next == 24'd0);
                phase_next   = frdone ? PH_HDR : first_body_phase(type_reg, flags_reg);
            end
            else
            begin
                hdr_cnt_next = 4'(n + 4'd1);
            end
        end
        else
        begin
            // Body bytes
            if (ph == PH_PAYLOAD)
            begin
                kind = (rem_reg <= {16'd0, pad_reg}) ? KIND_PADDING : KIND_PAYLOAD;
            end
            else
            begin
                kind        = phase_kind(ph);
                vshift_next = vs_shift;
                if (ph == PH_PING)
                begin
                    fdone     = (idx[1:0] == 2'd3);
                    phase_end = (idx == 3'd7);
                end
                else
                begin
                    fdone     = (idx_inc == field_len(ph));
                    phase_end = fdone;
                end
                bif_next = idx_inc;
                if (fdone)
                begin
                    fval        = vs_shift;
                    vshift_next = 32'd0;
                    if (ph == PH_PADLEN)
                        pad_next = data_byte;
                end
                if (phase_end)
                begin
                    phase_next  = next_phase(ph, type_reg, flags_reg);
                    bif_next    = 3'd0;
                    vshift_next = 32'd0;
                end
            end
            rem_next = rem_dec;
            if (rem_dec == 24'd0)
            begin
                frdone       = 1'b1;
                hdr_cnt_next = 4'd0;
                phase_next   = PH_HDR;
                bif_next     = 3'd0;
                vshift_next  = 32'd0;
            end
        end

        // Packet end returns to the header phase
        trunc = last_byte && !frdone;
        if (last_byte)
        begin
            hdr_cnt_next = 4'd0;
            phase_next   = PH_HDR;
            bif_next     = 3'd0;
            vshift_next  = 32'd0;
        end
    end

    // Result of this byte, with the frame registers as they stand after it
    always_comb
    begin
        result.field_kind   = kind;
        result.frame_type   = type_next;
        result.frame_flags  = flags_next;
        result.stream_id    = stream_next;
        result.frame_length = length_next;
        result.field_value  = fdone ? fval : 32'd0;
        result.field_done   = fdone;
        result.frame_done   = frdone;
        result.truncated    = trunc;
    end

    // Parser state, advanced on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            bif_reg     <= 3'd0;
            hdr_cnt_reg <= 4'd0;
            rem_reg     <= 24'd0;
            pad_reg     <= 8'd0;
            vshift_reg  <= 32'd0;
            type_reg    <= 8'd0;
            flags_reg   <= 8'd0;
            stream_reg  <= 32'd0;
            length_reg  <= 24'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            bif_reg     <= bif_next;
            hdr_cnt_reg <= hdr_cnt_next;
            rem_reg     <= rem_next;
            pad_reg     <= pad_next;
            vshift_reg  <= vshift_next;
            type_reg    <= type_next;
            flags_reg   <= flags_next;
            stream_reg  <= stream_next;
            length_reg  <= length_next;
        end
    end

endmodule

[hdl/hfd_skid.sv]
module hfd_skid
    import hfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    // The skid stage holds one transaction that arrives while the output stalls
    assign in_ready  = !skid_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_valid)
                out_data_reg <= in_data;
        end
        else if (in_valid && in_ready)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hfd_pkg::*;

    // Run sizing and watchdog limits
    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_AFTER     = 400;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 26;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    // One stimulus row: the byte, its packet marks and an optional typed result
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       has_exp;
        result_t    exp;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic [5:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // Typed result that travels alongside the byte on offer
    logic         cur_has_exp;
    result_t      cur_exp;

    // Parser state mirrored by the predictor
    phase_t       prs_phase;
    logic [2:0]   prs_byte_idx;
    logic [3:0]   prs_hdr_cnt;
    logic [23:0]  prs_remain;
    logic [7:0]   prs_pad;
    logic [31:0]  prs_shift;
    logic [7:0]   prs_type;
    logic [7:0]   prs_flags;
    logic [31:0]  prs_stream;
    logic [23:0]  prs_length;

    result_t      due_results[$];
    stim_row_t    random_rows[$];
    logic [7:0]   pkt_bytes[$];

    int           mismatch_count = 0;
    int           results_seen   = 0;
    int           frames_ended   = 0;
    int           truncations    = 0;
    int           fields_done    = 0;
    int           packets_built  = 0;
    int           burst_left     = 0;
    int           rx_hold_left   = 0;
    bit           hold_done      = 0;

    http2_frame_deframer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Builders for the directed stimulus rows
    function automatic result_t make_result(input logic [3:0] kind, input logic [7:0] ftype,
                                            input logic [7:0] flags, input logic [31:0] sid,
                                            input logic [23:0] flen, input logic [31:0] fval,
                                            input logic fdone, input logic frdone,
                                            input logic trunc);
        result_t r;
        begin
            r.field_kind   = kind;
            r.frame_type   = ftype;
            r.frame_flags  = flags;
            r.stream_id    = sid;
            r.frame_length = flen;
            r.field_value  = fval;
            r.field_done   = fdone;
            r.frame_done   = frdone;
            r.truncated    = trunc;
            return r;
        end
    endfunction

    function automatic stim_row_t plain(input logic [7:0] d, input logic f, input logic l);
        return '{data: d, first: f, last: l, has_exp: 1'b0, exp: '0};
    endfunction

    function automatic stim_row_t checked(input logic [7:0] d, input logic f, input logic l,
                                          input result_t r);
        return '{data: d, first: f, last: l, has_exp: 1'b1, exp: r};
    endfunction

    // Directed part: a window increment frame at the field extremes, a padded
    // data frame, and a one-byte packet that is cut inside the header.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        plain(8'h00, 1'b1, 1'b0),
        plain(8'h00, 1'b0, 1'b0),
        plain(8'h04, 1'b0, 1'b0),
        plain(FT_WINDOW, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        checked(8'hFF, 1'b0, 1'b0,
                make_result(KIND_HEADER, FT_WINDOW, 8'hFF, 32'hFFFF_FFFF,
                            24'd4, 32'd4, 1'b1, 1'b0, 1'b0)),
        plain(8'h7F, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        plain(8'hFF, 1'b0, 1'b0),
        checked(8'hFF, 1'b0, 1'b1,
                make_result(KIND_WINDOW, FT_WINDOW, 8'hFF, 32'hFFFF_FFFF,
                            24'd4, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0)),
        plain(8'h00, 1'b1, 1'b0),
        plain(8'h00, 1'b0, 1'b0),
        plain(8'h03, 1'b0, 1'b0),
        plain(FT_DATA, 1'b0, 1'b0),
        plain(FLAG_PADDED, 1'b0, 1'b0),
        plain(8'h00, 1'b0, 1'b0),
        plain(8'h00, 1'b0, 1'b0),
        plain(8'h00, 1'b0, 1'b0),
        plain(8'h01, 1'b0, 1'b0),
        checked(8'h02, 1'b0, 1'b0,
                make_result(KIND_PADLEN, FT_DATA, FLAG_PADDED, 32'd1,
                            24'd3, 32'd2, 1'b1, 1'b0, 1'b0)),
        plain(8'hAA, 1'b0, 1'b0),
        plain(8'hBB, 1'b0, 1'b0),
        checked(8'h5A, 1'b1, 1'b1,
                make_result(KIND_HEADER, FT_DATA, FLAG_PADDED, 32'd1,
                            24'h00005A, 32'd0, 1'b0, 1'b0, 1'b1))
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is held at the start of the run only.
    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Body phase that follows the pad length byte, or opens an unpadded body.
    function automatic phase_t body_phase_after_pad();
        begin
            case (prs_type)
                FT_HEADERS:      return ((prs_flags & FLAG_PRIORITY) != 8'd0) ? PH_DEP
                                                                              : PH_PAYLOAD;
                FT_PRIORITY:     return PH_DEP;
                FT_RST_STREAM:   return PH_ERROR;
                FT_SETTINGS:     return PH_SETID;
                FT_PUSH_PROMISE: return PH_PROMISED;
                FT_PING:         return PH_PING;
                FT_GOAWAY:       return PH_LASTID;
                FT_WINDOW:       return PH_WINDOW;
                default:         return PH_PAYLOAD;
            endcase
        end
    endfunction

    function automatic void enter_parse_phase(input phase_t ph);
        begin
            prs_phase    = ph;
            prs_byte_idx = 3'd0;
            prs_shift    = 32'd0;
        end
    endfunction

    function automatic void clear_parser();
        begin
            enter_parse_phase(PH_HDR);
            prs_hdr_cnt = 4'd0;
            prs_remain  = 24'd0;
            prs_pad     = 8'd0;
            prs_type    = 8'd0;
            prs_flags   = 8'd0;
            prs_stream  = 32'd0;
            prs_length  = 24'd0;
        end
    endfunction

    // Predicts the tagged result of one accepted byte and advances the parser.
    function automatic result_t deframe_byte(input logic [7:0] b, input logic first,
                                             input logic last_b);
        result_t    r;
        logic [3:0] n;
        logic [3:0] width;
        logic [2:0] idx;
        logic       padded_type;
        logic       phase_end;
        phase_t     ph;
        begin
            r = '0;
            if (first)
            begin
                prs_phase   = PH_HDR;
                prs_hdr_cnt = 4'd0;
            end

            if (prs_phase == PH_HDR || prs_remain == 24'd0)
            begin
                // Header byte: shift it into the register it belongs to.
                n = (prs_hdr_cnt > HDR_LAST_BYTE) ? 4'd0 : prs_hdr_cnt;
                prs_phase = PH_HDR;
                r.field_kind = KIND_HEADER;
                case (n)
                    4'd0:       prs_length = {16'd0, b};
                    4'd1, 4'd2: prs_length = {prs_length[15:0], b};
                    4'd3:       prs_type   = b;
                    4'd4:       prs_flags  = b;
                    4'd5:       prs_stream = {24'd0, b};
                    default:    prs_stream = {prs_stream[23:0], b};
                endcase
                if (n == HDR_LAST_BYTE)
                begin
                    prs_hdr_cnt   = 4'd0;
                    r.field_done  = 1'b1;
                    r.field_value = {8'd0, prs_length};
                    prs_remain    = prs_length;
                    prs_pad       = 8'd0;
                    if (prs_remain == 24'd0)
                    begin
                        r.frame_done = 1'b1;
                        enter_parse_phase(PH_HDR);
                    end
                    else
                    begin
                        padded_type = prs_type == FT_DATA || prs_type == FT_HEADERS
                                   || prs_type == FT_PUSH_PROMISE;
                        if (padded_type && (prs_flags & FLAG_PADDED) != 8'd0)
                            enter_parse_phase(PH_PADLEN);
                        else
                            enter_parse_phase(body_phase_after_pad());
                    end
                end
                else
                    prs_hdr_cnt = n + 4'd1;
            end
            else
            begin
                ph = prs_phase;
                if (ph == PH_PAYLOAD)
                    r.field_kind = (prs_remain <= {16'd0, prs_pad}) ? KIND_PADDING
                                                                    : KIND_PAYLOAD;
                else
                begin
                    // Fixed field byte: assemble big-endian and step through the layout.
                    idx = prs_byte_idx;
                    case (ph)
                        PH_PADLEN:   begin r.field_kind = KIND_PADLEN;     width = 4'd1; end
                        PH_DEP:      begin r.field_kind = KIND_DEPENDENCY; width = 4'd4; end
                        PH_WEIGHT:   begin r.field_kind = KIND_WEIGHT;     width = 4'd1; end
                        PH_PROMISED: begin r.field_kind = KIND_PROMISED;   width = 4'd4; end
                        PH_ERROR:    begin r.field_kind = KIND_ERROR;      width = 4'd4; end
                        PH_SETID:    begin r.field_kind = KIND_SET_ID;     width = 4'd2; end
                        PH_SETVAL:   begin r.field_kind = KIND_SET_VALUE;  width = 4'd4; end
                        PH_PING:     begin r.field_kind = KIND_PING;       width = 4'd4; end
                        PH_LASTID:   begin r.field_kind = KIND_LAST_ID;    width = 4'd4; end
                        default:     begin r.field_kind = KIND_WINDOW;     width = 4'd4; end
                    endcase
                    prs_shift = {prs_shift[23:0], b};
                    if (ph == PH_PING)
                    begin
                        // The two ping words complete one after the other.
                        r.field_done = idx[1:0] == 2'd3;
                        phase_end    = idx == 3'd7;
                    end
                    else
                    begin
                        r.field_done = ({1'b0, idx} + 4'd1) == width;
                        phase_end    = r.field_done;
                    end
                    prs_byte_idx = idx + 3'd1;
                    if (r.field_done)
                    begin
                        r.field_value = prs_shift;
                        prs_shift     = 32'd0;
                        if (ph == PH_PADLEN)
                            prs_pad = b;
                    end
                    if (phase_end)
                    begin
                        case (ph)
                            PH_PADLEN: enter_parse_phase(body_phase_after_pad());
                            PH_DEP:    enter_parse_phase(PH_WEIGHT);
                            PH_SETID:  enter_parse_phase(PH_SETVAL);
                            PH_SETVAL: enter_parse_phase(PH_SETID);
                            PH_LASTID: enter_parse_phase(PH_ERROR);
                            default:   enter_parse_phase(PH_PAYLOAD);
                        endcase
                    end
                end
                prs_remain = prs_remain - 24'd1;
                if (prs_remain == 24'd0)
                begin
                    r.frame_done = 1'b1;
                    prs_hdr_cnt  = 4'd0;
                    enter_parse_phase(PH_HDR);
                end
            end

            // A packet end always sends the parser back to a header.
            r.truncated = last_b && !r.frame_done;
            if (last_b)
            begin
                prs_hdr_cnt = 4'd0;
                enter_parse_phase(PH_HDR);
            end

            r.frame_type   = prs_type;
            r.frame_flags  = prs_flags;
            r.stream_id    = prs_stream;
            r.frame_length = prs_length;
            return r;
        end
    endfunction

    // Appends one frame to the packet under construction; returns 1 when the
    // frame carries a huge length and the packet has to end inside it.
    function automatic bit add_frame();
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [7:0]  plen;
        logic [31:0] sid;
        logic [23:0] flen;
        int          sel;
        int          fixed_len;
        int          data_len;
        bit          padded;
        bit          huge;
        begin
            sel    = $urandom_range(0, 19);
            ftype  = (sel < 17) ? 8'(sel % 9) : 8'($urandom_range(9, 255));
            flags  = 8'($urandom_range(0, 255));
            sid    = $urandom;
            padded = (ftype == FT_DATA || ftype == FT_HEADERS
                      || ftype == FT_PUSH_PROMISE) && (flags & FLAG_PADDED) != 8'd0;
            plen   = padded ? 8'($urandom_range(0, 6)) : 8'd0;
            huge   = 1'b0;
            case (ftype)
                FT_HEADERS:      fixed_len = ((flags & FLAG_PRIORITY) != 8'd0) ? 5 : 0;
                FT_PRIORITY:     fixed_len = 5;
                FT_RST_STREAM:   fixed_len = 4;
                FT_SETTINGS:     fixed_len = 6 * $urandom_range(0, 3);
                FT_PUSH_PROMISE: fixed_len = 4;
                FT_PING:         fixed_len = 8;
                FT_GOAWAY:       fixed_len = 8;
                FT_WINDOW:       fixed_len = 4;
                default:         fixed_len = 0;
            endcase
            data_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            flen = 24'((padded ? 1 : 0) + fixed_len + data_len + plen);

            // Occasional broken frames: a length that cuts fields or a wild pad
            // length, and rarely a length far beyond the packet.
            case ($urandom_range(0, 15))
                0:
                begin
                    flen = 24'($urandom_range(0, 12));
                    plen = 8'($urandom_range(0, 255));
                end
                1:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        flen = {1'b1, 23'($urandom)};
                        huge = 1'b1;
                    end
                end
                default: ;
            endcase

            pkt_bytes.push_back(flen[23:16]);
            pkt_bytes.push_back(flen[15:8]);
            pkt_bytes.push_back(flen[7:0]);
            pkt_bytes.push_back(ftype);
            pkt_bytes.push_back(flags);
            pkt_bytes.push_back(sid[31:24]);
            pkt_bytes.push_back(sid[23:16]);
            pkt_bytes.push_back(sid[15:8]);
            pkt_bytes.push_back(sid[7:0]);
            if (huge)
            begin
                repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
                return 1'b1;
            end
            for (int i = 0; i < int'(flen); i++)
                pkt_bytes.push_back((i == 0 && padded) ? plen : 8'($urandom));
            return 1'b0;
        end
    endfunction

    // Builds one packet of random content: mostly whole frames, sometimes
    // cut short, and now and then loose bytes with random packet marks.
    function automatic void build_packet();
        int cut;
        begin
            pkt_bytes.delete();
            packets_built++;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    random_rows.push_back(plain(8'($urandom), $urandom_range(0, 3) == 0,
                                                $urandom_range(0, 3) == 0));
                return;
            end
            repeat ($urandom_range(1, 4))
                if (add_frame())
                    break;
            if ($urandom_range(0, 5) == 0 && pkt_bytes.size() > 1)
            begin
                cut = $urandom_range(1, pkt_bytes.size() - 1);
                repeat (cut) void'(pkt_bytes.pop_back());
            end
            foreach (pkt_bytes[i])
                random_rows.push_back(plain(pkt_bytes[i], i == 0, i == pkt_bytes.size() - 1));
        end
    endfunction

    // Offers one byte, with bursts and random gaps, and waits for its transaction.
    task automatic drive_item(input stim_row_t row);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                         : $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (rx_hold_left != 0)
                    gap = 0;
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= row.data;
            s_axis_tuser  <= row.first;
            s_axis_tlast  <= row.last;
            cur_has_exp   <= row.has_exp;
            cur_exp       <= row.exp;
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
        end
    endtask

    // Stops offering until every outstanding result has been delivered.
    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            @(posedge clk);
            while (due_results.size() != 0) @(posedge clk);
        end
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        begin
            if (got !== want)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("Mismatch on result %0d, %s: expected %h, got %h",
                             results_seen, fname, want, got);
                mismatch_count++;
            end
        end
    endtask

    // Sender: directed rows, a drain pause, then the random packets with a drain halfway.
    initial
    begin : stimulus
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        cur_has_exp   <= 1'b0;
        cur_exp       <= '0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            drive_item(DIRECTED[i]);
        wait_drained();

        while (random_rows.size() < RANDOM_ITEMS)
            build_packet();
        foreach (random_rows[i])
        begin
            if (i == random_rows.size() / 2)
                wait_drained();
            drive_item(random_rows[i]);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (due_results.size() != 0)
        begin
            $display("%0d expected results never arrived", due_results.size());
            mismatch_count++;
        end
        $display("Run covered %0d bytes (%0d directed, %0d random packets) and %0d results.",
                 DIRECTED_ROWS + random_rows.size(), DIRECTED_ROWS, packets_built,
                 results_seen);
        $display("Frames ended: %0d, fields assembled: %0d, truncated packets: %0d.",
                 frames_ended, fields_done, truncations);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: changing stall patterns, plus one long hold-off that fills the block.
    initial
    begin : receiver
        rx_mode_t    mode;
        int          mode_left;
        int unsigned cyc;
        m_axis_tready <= 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rx_hold_left == 0 && !hold_done && results_seen >= HOLD_AFTER)
            begin
                rx_hold_left = HOLD_CYCLES;
                hold_done    = 1'b1;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   m_axis_tready <= 1'b1;
                    RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_axis_tready <= (cyc % 4) != 0;
                    default:     m_axis_tready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    // Input side: every accepted byte is predicted at once.
    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        result_t want;
        if (!rst_n)
            clear_parser();
        else if (s_axis_tvalid && s_axis_tready)
        begin
            want = deframe_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            if (cur_has_exp)
                want = cur_exp;
            due_results.push_back(want);
        end
    end

    // Output side: each result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame_type   = m_axis_tdata[7:0];
            got.frame_flags  = m_axis_tdata[15:8];
            got.stream_id    = m_axis_tdata[47:16];
            got.frame_length = m_axis_tdata[71:48];
            got.field_value  = m_axis_tdata[103:72];
            got.field_kind   = m_axis_tuser[3:0];
            got.field_done   = m_axis_tuser[4];
            got.truncated    = m_axis_tuser[5];
            got.frame_done   = m_axis_tlast;
            if (due_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("Unexpected result %0d: %h", results_seen, got);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("field_kind",   32'(want.field_kind),   32'(got.field_kind));
                compare_field("frame_type",   32'(want.frame_type),   32'(got.frame_type));
                compare_field("frame_flags",  32'(want.frame_flags),  32'(got.frame_flags));
                compare_field("stream_id",    want.stream_id,         got.stream_id);
                compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
                compare_field("field_value",  want.field_value,       got.field_value);
                compare_field("field_done",   32'(want.field_done),   32'(got.field_done));
                compare_field("frame_done",   32'(want.frame_done),   32'(got.frame_done));
                compare_field("truncated",    32'(want.truncated),    32'(got.truncated));
                if (want.frame_done)
                    frames_ended++;
                if (want.field_done)
                    fields_done++;
                if (want.truncated)
                    truncations++;
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/hfd_pkg.sv
hdl/hfd_parse.sv
hdl/hfd_skid.sv
hdl/http2_frame_deframer_top.sv
verif/testbench.sv
